FILE: hw/rtl/utf8v_pkg.sv
// Shared types and byte constants for the UTF-8 BMP text validator.
`default_nettype none
package utf8v_pkg;

   localparam logic [7:0] CTRL_LIMIT   = 8'h20;
   localparam logic [7:0] DEL_CHAR     = 8'h7f;
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_LO     = 8'hc2;
   localparam logic [7:0] LEAD2_HI     = 8'hdf;
   localparam logic [7:0] LEAD3_LO     = 8'he0;
   localparam logic [7:0] LEAD3_HI     = 8'hef;
   localparam logic [7:0] LEAD3_SURR   = 8'hed;
   localparam logic [7:0] SECOND_SPLIT = 8'ha0;
   localparam logic [7:0] CONT_MASK    = 8'hc0;
   localparam logic [7:0] CONT_TAG     = 8'h80;

   typedef enum logic [1:0] {
      RULE_NONE     = 2'd0,
      RULE_MIN_A0   = 2'd1,
      RULE_BELOW_A0 = 2'd2
   } rule_type;

   typedef struct packed {
      logic [1:0] pending;
      logic [1:0] rule;
      logic       err;
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/utf8v_step.sv
// Per-word decode step: next validator state and verdict from current state and one word.
`default_nettype none
module utf8v_step (
   input  utf8v_pkg::state_type cur_state,
   input  logic [7:0]           byte_value,
   input  logic                 has_byte,
   input  logic                 last,
   output utf8v_pkg::state_type nxt_state,
   output logic                 string_ok
);
   import utf8v_pkg::*;

   utf8v_pkg::state_type upd;
   logic                 bad;

   always_comb begin
      upd = cur_state;
      bad = 1'b0;
      if (has_byte && !cur_state.err) begin
         if (cur_state.pending != 2'd0) begin
            bad = (byte_value & CONT_MASK) != CONT_TAG;
            case (cur_state.rule)
               RULE_MIN_A0:   if (byte_value < SECOND_SPLIT) bad = 1'b1;
               RULE_BELOW_A0: if (byte_value >= SECOND_SPLIT) bad = 1'b1;
               default:       ;
            endcase
            if (bad) begin
               upd.err = 1'b1;
            end else begin
               upd.pending = cur_state.pending - 2'd1;
               upd.rule    = RULE_NONE;
            end
         end else if (byte_value < CTRL_LIMIT || byte_value == DEL_CHAR) begin
            upd.err = 1'b1;
         end else if (byte_value < ASCII_LIMIT) begin
            upd = cur_state;
         end else if (byte_value inside {[LEAD2_LO:LEAD2_HI]}) begin
            upd.pending = 2'd1;
            upd.rule    = RULE_NONE;
         end else if (byte_value inside {[LEAD3_LO:LEAD3_HI]}) begin
            upd.pending = 2'd2;
            if (byte_value == LEAD3_LO) begin
               upd.rule = RULE_MIN_A0;
            end else if (byte_value == LEAD3_SURR) begin
               upd.rule = RULE_BELOW_A0;
            end else begin
               upd.rule = RULE_NONE;
            end
         end else begin
            upd.err = 1'b1;
         end
      end
   end

   assign string_ok = !upd.err && !(last && upd.pending != 2'd0);
   assign nxt_state = last ? '0 : upd;

endmodule
`default_nettype wire

FILE: hw/rtl/utf8v_core.sv
// Validator state registers around the decode step.
`default_nettype none
module utf8v_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] byte_value,
   input  logic       has_byte,
   input  logic       last,
   output logic       string_ok
);
   import utf8v_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type step_nxt;

   utf8v_step u_step (
      .cur_state  (state_ff),
      .byte_value (byte_value),
      .has_byte   (has_byte),
      .last       (last),
      .nxt_state  (step_nxt),
      .string_ok  (string_ok)
   );

   assign state_in = advance ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && last |=> state_ff == '0)
      else $error("state not cleared after end of string");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && !last && state_ff.err |=> state_ff.err)
      else $error("error flag dropped inside a string");

   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending != 2'd3)
      else $error("continuation count out of range");

   a_ok_implies_clean: assert property (@(posedge clock) disable iff (reset)
      advance && string_ok |-> !step_nxt.err)
      else $error("verdict ok with error recorded");

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_bmp_text_validator.sv
// Top level of the streaming UTF-8 BMP text validator.
// Checks a string one byte word per cycle against UTF-8 limited to one- to
// three-byte sequences (no control characters, no overlongs, no surrogates).
// Each accepted word yields exactly one result: rsp_string_ok is the verdict so
// far and rsp_string_end mirrors req_last; on the last word an unfinished
// sequence fails, and state clears for the next string. A word without a byte
// (req_has_byte low) only reports, so an empty string passes. Throughput is one
// word per cycle while rsp_stall is low; each word passes the input register,
// then the decode step, into the result register.
`default_nettype none
module utf8_bmp_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_string_ok,
   output logic       rsp_string_end
);
   import utf8v_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_has_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff;
   logic       rsp_end_ff;
   logic       advance;
   logic       req_take;
   logic       step_ok;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   utf8v_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_value (s1_byte_ff),
      .has_byte   (s1_has_ff),
      .last       (s1_last_ff),
      .string_ok  (step_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_byte_value;
         s1_has_ff  <= req_has_byte;
         s1_last_ff <= req_last;
      end
      if (advance) begin
         rsp_ok_ff  <= step_ok;
         rsp_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_string_ok  = rsp_ok_ff;
   assign rsp_string_end = rsp_end_ff;

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with free pipeline slot");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ok_ff) && $stable(rsp_end_ff))
      else $error("stalled result word changed");

endmodule
`default_nettype wire
